// ===== rtl/pre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_pkg
// Shared widths, sizes, operation codes and result codes of the partition refinement engine.
// ----------------------------------------------------------------------------
package pre_pkg;

    localparam int MAX_OBJECTS = 1024;
    localparam int MAX_GROUP   = 1024;
    localparam int ID_W        = 10;
    localparam int CNT_W       = 11;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_MEMBER   = 2'd0;
    localparam logic [OP_W-1:0] OP_FINALIZE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;

    localparam logic [OP_W-1:0] KIND_REFINED   = 2'd0;
    localparam logic [OP_W-1:0] KIND_FINALIZED = 2'd1;
    localparam logic [OP_W-1:0] KIND_LOOKUP    = 2'd2;

    localparam logic [CNT_W-1:0] MAX_OBJ_C   = CNT_W'(MAX_OBJECTS);
    localparam logic [CNT_W-1:0] MAX_GROUP_C = CNT_W'(MAX_GROUP);

endpackage

// ===== rtl/partition_refinement_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_refinement_engine_top
// Partition refinement over object ids kept in on-chip synchronous memories.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the owner and hit-count
// memories and holds in_stall high meanwhile. The block then works on one word
// at a time. A group member that is not last is only stored. A lookup reads the
// owner entry and, for an object with a set, the set size; an id outside the
// universe goes straight to the result. A group close runs a counting pass over
// the stored members and then visits each touched set. Each set that is split
// takes another pass over the stored members and then writes both sizes.
// Gathering the members that had no set takes one more pass over the members.
// Finalize walks every owner entry of the clamped universe. This sequencing
// follows from the single read port of each memory and its registered read
// data. Results sit in an output register, so a new word is taken while a
// result still waits.
// ----------------------------------------------------------------------------
module partition_refinement_engine_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pre_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pre_pkg::OP_W-1:0]      op,
    input  logic [pre_pkg::ID_W-1:0]      object_id,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pre_pkg::OP_W-1:0]      result_kind,
    output logic [pre_pkg::ID_W-1:0]      set_id,
    output logic                          assigned,
    output logic [pre_pkg::CNT_W-1:0]     member_count,
    output logic [pre_pkg::CNT_W-1:0]     set_total
);

    localparam int ID_W  = pre_pkg::ID_W;
    localparam int CNT_W = pre_pkg::CNT_W;

    // Sequencer states.
    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_A0   = 5'd2;
    localparam logic [4:0] S_A1   = 5'd3;
    localparam logic [4:0] S_A2   = 5'd4;
    localparam logic [4:0] S_A3   = 5'd5;
    localparam logic [4:0] S_B0   = 5'd6;
    localparam logic [4:0] S_B1   = 5'd7;
    localparam logic [4:0] S_B2   = 5'd8;
    localparam logic [4:0] S_BM0  = 5'd9;
    localparam logic [4:0] S_BM1  = 5'd10;
    localparam logic [4:0] S_BM2  = 5'd11;
    localparam logic [4:0] S_BW   = 5'd12;
    localparam logic [4:0] S_BW2  = 5'd13;
    localparam logic [4:0] S_B3   = 5'd14;
    localparam logic [4:0] S_C0   = 5'd15;
    localparam logic [4:0] S_CM0  = 5'd16;
    localparam logic [4:0] S_CM1  = 5'd17;
    localparam logic [4:0] S_CM2  = 5'd18;
    localparam logic [4:0] S_CW   = 5'd19;
    localparam logic [4:0] S_F0   = 5'd20;
    localparam logic [4:0] S_F1   = 5'd21;
    localparam logic [4:0] S_L1   = 5'd22;
    localparam logic [4:0] S_L2   = 5'd23;
    localparam logic [4:0] S_EMIT = 5'd24;

    logic [4:0]       state_reg, state_next;
    logic [ID_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0] obj_count_reg;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] glen_reg, glen_next;
    logic [CNT_W-1:0] tt_reg, tt_next;
    logic [CNT_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] sets_reg, sets_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] moved_reg, moved_next;
    logic [CNT_W-1:0] sz_reg, sz_next;
    logic [ID_W-1:0]  s_reg, s_next;
    logic [ID_W-1:0]  m_reg, m_next;

    // Pending result, copied to the output register when the slot is free.
    logic [pre_pkg::OP_W-1:0] kind_reg, kind_next;
    logic [ID_W-1:0]          rid_reg, rid_next;
    logic                     ras_reg, ras_next;
    logic [CNT_W-1:0]         rcnt_reg, rcnt_next;

    logic                     out_valid_reg;
    logic [pre_pkg::OP_W-1:0] out_kind_reg;
    logic [ID_W-1:0]          out_id_reg;
    logic                     out_as_reg;
    logic [CNT_W-1:0]         out_cnt_reg;
    logic [CNT_W-1:0]         out_tot_reg;
    logic                     out_free;
    logic                     out_load;

    // Memory ports.
    logic             own_we, hit_we, siz_we, tch_we, gm_we;
    logic [ID_W-1:0]  own_wa, hit_wa, siz_wa, tch_wa, gm_wa;
    logic [CNT_W-1:0] own_wd, hit_wd, siz_wd;
    logic [ID_W-1:0]  tch_wd, gm_wd;
    logic [ID_W-1:0]  own_ra, hit_ra, siz_ra, tch_ra, gm_ra;
    logic [CNT_W-1:0] own_q, hit_q, siz_q;
    logic [ID_W-1:0]  tch_q, gm_q;

    logic accept;

    // Owner entries hold zero for no set, else the set id plus one.
    pre_ram #(.WIDTH(CNT_W), .DEPTH(pre_pkg::MAX_OBJECTS)) u_owner (
        .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
        .raddr(own_ra), .rdata(own_q)
    );

    pre_ram #(.WIDTH(CNT_W), .DEPTH(pre_pkg::MAX_OBJECTS)) u_hits (
        .clk(clk), .we(hit_we), .waddr(hit_wa), .wdata(hit_wd),
        .raddr(hit_ra), .rdata(hit_q)
    );

    pre_ram #(.WIDTH(CNT_W), .DEPTH(pre_pkg::MAX_OBJECTS)) u_size (
        .clk(clk), .we(siz_we), .waddr(siz_wa), .wdata(siz_wd),
        .raddr(siz_ra), .rdata(siz_q)
    );

    pre_ram #(.WIDTH(ID_W), .DEPTH(pre_pkg::MAX_OBJECTS)) u_touched (
        .clk(clk), .we(tch_we), .waddr(tch_wa), .wdata(tch_wd),
        .raddr(tch_ra), .rdata(tch_q)
    );

    pre_ram #(.WIDTH(ID_W), .DEPTH(pre_pkg::MAX_GROUP)) u_members (
        .clk(clk), .we(gm_we), .waddr(gm_wa), .wdata(gm_wd),
        .raddr(gm_ra), .rdata(gm_q)
    );

    // The universe size is clamped to one through MAX_OBJECTS.
    always_comb
    begin
        if (obj_count_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (obj_count_reg > pre_pkg::MAX_OBJ_C)
        begin
            lim = pre_pkg::MAX_OBJ_C;
        end
        else
        begin
            lim = obj_count_reg;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        glen_next  = glen_reg;
        tt_next    = tt_reg;
        t_next     = t_reg;
        i_next     = i_reg;
        sets_next  = sets_reg;
        n_next     = n_reg;
        moved_next = moved_reg;
        sz_next    = sz_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        kind_next  = kind_reg;
        rid_next   = rid_reg;
        ras_next   = ras_reg;
        rcnt_next  = rcnt_reg;

        own_we = 1'b0; own_wa = m_reg; own_wd = '0; own_ra = i_reg[ID_W-1:0];
        hit_we = 1'b0; hit_wa = s_reg; hit_wd = '0; hit_ra = s_reg;
        siz_we = 1'b0; siz_wa = s_reg; siz_wd = '0; siz_ra = s_reg;
        tch_we = 1'b0; tch_wa = tt_reg[ID_W-1:0]; tch_wd = s_reg;
        tch_ra = t_reg[ID_W-1:0];
        gm_we  = 1'b0; gm_wa = glen_reg[ID_W-1:0]; gm_wd = object_id;
        gm_ra  = i_reg[ID_W-1:0];

        case (state_reg)
            S_CLR:
            begin
                own_we = 1'b1; own_wa = clr_reg; own_wd = '0;
                hit_we = 1'b1; hit_wa = clr_reg; hit_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ID_W'(pre_pkg::MAX_OBJECTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                own_ra = object_id;
                if (accept)
                begin
                    rid_next  = '0;
                    ras_next  = 1'b0;
                    rcnt_next = '0;
                    case (op)
                        pre_pkg::OP_MEMBER:
                        begin
                            if ({1'b0, object_id} < lim && glen_reg < pre_pkg::MAX_GROUP_C)
                            begin
                                gm_we     = 1'b1;
                                glen_next = glen_reg + 1'b1;
                            end
                            if (last)
                            begin
                                kind_next  = pre_pkg::KIND_REFINED;
                                tt_next    = '0;
                                i_next     = '0;
                                state_next = S_A0;
                            end
                        end
                        pre_pkg::OP_FINALIZE:
                        begin
                            kind_next  = pre_pkg::KIND_FINALIZED;
                            moved_next = '0;
                            n_next     = sets_reg;
                            i_next     = '0;
                            state_next = (sets_reg < pre_pkg::MAX_OBJ_C) ? S_F0 : S_CW;
                        end
                        pre_pkg::OP_LOOKUP:
                        begin
                            kind_next  = pre_pkg::KIND_LOOKUP;
                            state_next = ({1'b0, object_id} < lim) ? S_L1 : S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            // Counting pass: hits per touched set, in order of first touch.
            S_A0:
            begin
                if (i_reg == glen_reg)
                begin
                    t_next     = '0;
                    state_next = S_B0;
                end
                else
                begin
                    state_next = S_A1;
                end
            end
            S_A1:
            begin
                own_ra     = gm_q;
                state_next = S_A2;
            end
            S_A2:
            begin
                s_next = ID_W'(own_q - 1'b1);
                hit_ra = ID_W'(own_q - 1'b1);
                if (own_q != '0)
                begin
                    state_next = S_A3;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_A0;
                end
            end
            S_A3:
            begin
                if (hit_q == '0 && tt_reg < pre_pkg::MAX_OBJ_C)
                begin
                    tch_we  = 1'b1;
                    tt_next = tt_reg + 1'b1;
                end
                hit_we     = 1'b1;
                hit_wd     = hit_q + 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = S_A0;
            end
            // Split pass over the touched sets.
            S_B0:
            begin
                state_next = (t_reg == tt_reg) ? S_C0 : S_B1;
            end
            S_B1:
            begin
                s_next     = tch_q;
                hit_ra     = tch_q;
                siz_ra     = tch_q;
                state_next = S_B2;
            end
            S_B2:
            begin
                if (hit_q < siz_q && sets_reg < pre_pkg::MAX_OBJ_C)
                begin
                    sz_next    = siz_q;
                    n_next     = sets_reg;
                    sets_next  = sets_reg + 1'b1;
                    moved_next = '0;
                    i_next     = '0;
                    state_next = S_BM0;
                end
                else
                begin
                    state_next = S_B3;
                end
            end
            S_BM0:
            begin
                state_next = (i_reg == glen_reg) ? S_BW : S_BM1;
            end
            S_BM1:
            begin
                m_next     = gm_q;
                own_ra     = gm_q;
                state_next = S_BM2;
            end
            S_BM2:
            begin
                if (own_q == {1'b0, s_reg} + 1'b1)
                begin
                    own_we     = 1'b1;
                    own_wd     = n_reg + 1'b1;
                    moved_next = moved_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_BM0;
            end
            S_BW:
            begin
                siz_we     = 1'b1;
                siz_wd     = sz_reg - moved_reg;
                state_next = S_BW2;
            end
            S_BW2:
            begin
                siz_we     = 1'b1;
                siz_wa     = n_reg[ID_W-1:0];
                siz_wd     = moved_reg;
                state_next = S_B3;
            end
            S_B3:
            begin
                hit_we     = 1'b1;
                hit_wd     = '0;
                t_next     = t_reg + 1'b1;
                state_next = S_B0;
            end
            // Members that had no set form one new set.
            S_C0:
            begin
                moved_next = '0;
                n_next     = sets_reg;
                i_next     = '0;
                state_next = (sets_reg < pre_pkg::MAX_OBJ_C) ? S_CM0 : S_CW;
            end
            S_CM0:
            begin
                state_next = (i_reg == glen_reg) ? S_CW : S_CM1;
            end
            S_CM1:
            begin
                m_next     = gm_q;
                own_ra     = gm_q;
                state_next = S_CM2;
            end
            S_CM2:
            begin
                if (own_q == '0)
                begin
                    own_we     = 1'b1;
                    own_wd     = n_reg + 1'b1;
                    moved_next = moved_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_CM0;
            end
            S_CW:
            begin
                if (moved_reg != '0)
                begin
                    sets_next = sets_reg + 1'b1;
                    siz_we    = 1'b1;
                    siz_wa    = n_reg[ID_W-1:0];
                    siz_wd    = moved_reg;
                end
                if (kind_reg == pre_pkg::KIND_REFINED)
                begin
                    glen_next = '0;
                    tt_next   = '0;
                end
                state_next = S_EMIT;
            end
            // Finalize sweeps every owner entry of the universe.
            S_F0:
            begin
                state_next = (i_reg == lim) ? S_CW : S_F1;
            end
            S_F1:
            begin
                if (own_q == '0)
                begin
                    own_we     = 1'b1;
                    own_wa     = i_reg[ID_W-1:0];
                    own_wd     = n_reg + 1'b1;
                    moved_next = moved_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_F0;
            end
            S_L1:
            begin
                s_next = ID_W'(own_q - 1'b1);
                siz_ra = ID_W'(own_q - 1'b1);
                state_next = (own_q != '0) ? S_L2 : S_EMIT;
            end
            S_L2:
            begin
                rid_next   = s_reg;
                ras_next   = 1'b1;
                rcnt_next  = siz_q;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            obj_count_reg <= pre_pkg::MAX_OBJ_C;
            glen_reg      <= '0;
            tt_reg        <= '0;
            t_reg         <= '0;
            i_reg         <= '0;
            sets_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            glen_reg  <= glen_next;
            tt_reg    <= tt_next;
            t_reg     <= t_next;
            i_reg     <= i_next;
            sets_reg  <= sets_next;
            if (cfg_we)
            begin
                obj_count_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        moved_reg <= moved_next;
        sz_reg    <= sz_next;
        s_reg     <= s_next;
        m_reg     <= m_next;
        kind_reg  <= kind_next;
        rid_reg   <= rid_next;
        ras_reg   <= ras_next;
        rcnt_reg  <= rcnt_next;
        if (out_load)
        begin
            out_kind_reg <= kind_reg;
            out_id_reg   <= rid_reg;
            out_as_reg   <= ras_reg;
            out_cnt_reg  <= rcnt_reg;
            out_tot_reg  <= sets_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign set_id       = out_id_reg;
    assign assigned     = out_as_reg;
    assign member_count = out_cnt_reg;
    assign set_total    = out_tot_reg;

endmodule

// ===== rtl/pre_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pre_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the partition refinement engine. It drives group
// members, finalize and lookup words through the input channel and predicts
// every answer with its own model of the partition. Each answer is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int OP_W        = pre_pkg::OP_W;
    localparam int ID_W        = pre_pkg::ID_W;
    localparam int CNT_W       = pre_pkg::CNT_W;
    localparam int MAX_OBJECTS = pre_pkg::MAX_OBJECTS;
    localparam int MAX_GROUP   = pre_pkg::MAX_GROUP;

    // Operation code three has no meaning and must be dropped by the block.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CLEAR_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 20000000;

    typedef struct packed {
        logic [OP_W-1:0]  kind;
        logic [ID_W-1:0]  sid;
        logic             asg;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] tot;
    } answer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  op = '0;
    logic [ID_W-1:0]  object_id = '0;
    logic             last = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [OP_W-1:0]  result_kind;
    logic [ID_W-1:0]  set_id;
    logic             assigned;
    logic [CNT_W-1:0] member_count;
    logic [CNT_W-1:0] set_total;

    partition_refinement_engine_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .object_id    (object_id),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .set_id       (set_id),
        .assigned     (assigned),
        .member_count (member_count),
        .set_total    (set_total)
    );

    always #2 clk = ~clk;

    // Partition state as the bench believes it to be. An owner of zero means
    // the object has no set yet; otherwise the owner is the set number plus one.
    int      owner [MAX_OBJECTS];
    int      set_size [MAX_OBJECTS];
    int      hit_count [MAX_OBJECTS];
    int      open_group [$];
    int      sets_used;
    int      universe_reg;
    answer_t pending_answers [$];

    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    // The block clamps the universe register into one through MAX_OBJECTS.
    function automatic int universe();
        if (universe_reg < 1)
            return 1;
        if (universe_reg > MAX_OBJECTS)
            return MAX_OBJECTS;
        return universe_reg;
    endfunction

    // Closing a group splits every touched set that the group covers only in
    // part, in the order the sets were first touched, then gathers members
    // that had no set into one new set.
    function automatic void close_open_group();
        int touched [$];
        int s;
        int n;
        int moved;
        touched = {};
        foreach (open_group[i])
        begin
            if (owner[open_group[i]] != 0)
            begin
                s = owner[open_group[i]] - 1;
                if (hit_count[s] == 0)
                    touched = {touched, s};
                hit_count[s]++;
            end
        end
        foreach (touched[t])
        begin
            s = touched[t];
            if (hit_count[s] < set_size[s] && sets_used < MAX_OBJECTS)
            begin
                n = sets_used;
                sets_used++;
                moved = 0;
                foreach (open_group[i])
                begin
                    if (owner[open_group[i]] == s + 1)
                    begin
                        owner[open_group[i]] = n + 1;
                        moved++;
                    end
                end
                set_size[s] -= moved;
                set_size[n] = moved;
            end
            hit_count[s] = 0;
        end
        if (sets_used < MAX_OBJECTS)
        begin
            n = sets_used;
            moved = 0;
            foreach (open_group[i])
            begin
                if (owner[open_group[i]] == 0)
                begin
                    owner[open_group[i]] = n + 1;
                    moved++;
                end
            end
            if (moved > 0)
            begin
                sets_used++;
                set_size[n] = moved;
            end
        end
        open_group = {};
    endfunction

    function automatic void finalize_universe();
        int moved;
        moved = 0;
        if (sets_used >= MAX_OBJECTS)
            return;
        for (int i = 0; i < universe(); i++)
        begin
            if (owner[i] == 0)
            begin
                owner[i] = sets_used + 1;
                moved++;
            end
        end
        if (moved > 0)
        begin
            set_size[sets_used] = moved;
            sets_used++;
        end
    endfunction

    // Applies one accepted word to the partition and queues its answer, if any.
    function automatic void predict_partition(logic [OP_W-1:0] w_op, int w_id, logic w_last);
        answer_t a;
        a = '0;
        if (w_op == pre_pkg::OP_MEMBER)
        begin
            if (w_id < universe() && open_group.size() < MAX_GROUP)
                open_group = {open_group, w_id};
            if (!w_last)
                return;
            close_open_group();
            a.kind = pre_pkg::KIND_REFINED;
        end
        else if (w_op == pre_pkg::OP_FINALIZE)
        begin
            finalize_universe();
            a.kind = pre_pkg::KIND_FINALIZED;
        end
        else if (w_op == pre_pkg::OP_LOOKUP)
        begin
            a.kind = pre_pkg::KIND_LOOKUP;
            if (w_id < universe() && owner[w_id] != 0)
            begin
                a.sid = ID_W'(owner[w_id] - 1);
                a.asg = 1'b1;
                a.cnt = CNT_W'(set_size[owner[w_id] - 1]);
            end
        end
        else
            return;
        a.tot = CNT_W'(sets_used);
        pending_answers = {pending_answers, a};
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        errors++;
        $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // Offers one word, with a random idle gap ahead of it, and waits until the
    // block takes it. Valid is only lowered when a gap is really inserted.
    task automatic send_word(logic [OP_W-1:0] w_op, int w_id, logic w_last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= w_op;
        object_id <= ID_W'(w_id);
        last      <= w_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_partition(w_op, w_id, w_last);
    endtask

    // Waits until every answer is back, plus a margin for words that give no
    // answer and may still be in flight.
    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() > 0)
            @(posedge clk);
        repeat (CLEAR_CYCLES) @(posedge clk);
    endtask

    task automatic write_universe(int value);
        drain_answers();
        cfg_we   <= 1'b1;
        cfg_data <= CNT_W'(value);
        @(posedge clk);
        cfg_we   <= 1'b0;
        universe_reg = value & 11'h7FF;
    endtask

    // A random id, mostly inside the universe so that groups collide often.
    function automatic int pick_id();
        if ($urandom_range(99) < 10)
            return $urandom_range(MAX_OBJECTS - 1);
        return $urandom_range(universe() - 1);
    endfunction

    // Mostly well-formed groups of up to six members, with lookups, finalize,
    // and the odd unused code in between.
    task automatic random_words(int count);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++)
                begin
                    send_word(pre_pkg::OP_MEMBER, pick_id(), k == len - 1);
                    sent++;
                    if (k < len - 1 && $urandom_range(99) < 8)
                    begin
                        send_word(pre_pkg::OP_LOOKUP, pick_id(), 1'($urandom_range(1)));
                        sent++;
                    end
                end
            end
            else if (pick < 90)
            begin
                send_word(pre_pkg::OP_LOOKUP, pick_id(), 1'($urandom_range(1)));
                sent++;
            end
            else if (pick < 95)
            begin
                send_word(pre_pkg::OP_FINALIZE, $urandom_range(MAX_OBJECTS - 1),
                          1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                send_word(OP_UNUSED, $urandom_range(MAX_OBJECTS - 1), 1'($urandom_range(1)));
            end
        end
    endtask

    // Fresh state after reset: lookups at the universe edges, with the reset
    // universe still in force.
    task automatic test_reset_state();
        send_word(pre_pkg::OP_LOOKUP, 0, 1'b0);
        send_word(pre_pkg::OP_LOOKUP, MAX_OBJECTS - 1, 1'b1);
    endtask

    // Every operation and each corner of refinement in a universe of eight.
    task automatic test_directed();
        write_universe(8);
        send_word(pre_pkg::OP_MEMBER, 0, 1'b0);
        send_word(pre_pkg::OP_MEMBER, 1, 1'b1);
        // Partial cover of a set, a new member and one outside the universe.
        send_word(pre_pkg::OP_MEMBER, 1, 1'b0);
        send_word(pre_pkg::OP_MEMBER, 2, 1'b0);
        send_word(pre_pkg::OP_MEMBER, 9, 1'b1);
        send_word(pre_pkg::OP_LOOKUP, 1, 1'b0);
        send_word(OP_UNUSED, 1023, 1'b1);
        send_word(pre_pkg::OP_FINALIZE, 0, 1'b0);
        send_word(pre_pkg::OP_FINALIZE, 0, 1'b0);
        send_word(pre_pkg::OP_LOOKUP, 9, 1'b0);
        // A repeated member moves only once.
        send_word(pre_pkg::OP_MEMBER, 3, 1'b0);
        send_word(pre_pkg::OP_MEMBER, 3, 1'b1);
        send_word(pre_pkg::OP_LOOKUP, 3, 1'b0);
        send_word(pre_pkg::OP_LOOKUP, 4, 1'b0);
        // A group that holds only a dropped member still closes.
        send_word(pre_pkg::OP_MEMBER, 9, 1'b1);
        // Lookup and finalize while a group is still open.
        send_word(pre_pkg::OP_MEMBER, 4, 1'b0);
        send_word(pre_pkg::OP_LOOKUP, 4, 1'b0);
        send_word(pre_pkg::OP_FINALIZE, 0, 1'b0);
        send_word(pre_pkg::OP_MEMBER, 5, 1'b1);
        send_word(pre_pkg::OP_LOOKUP, 5, 1'b0);
        send_word(pre_pkg::OP_LOOKUP, 7, 1'b1);
    endtask

    task automatic test_random_phase(int count, int universe_size, int send_pct, int recv_pct);
        write_universe(universe_size);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        random_words(count);
    endtask

    // The receiver holds off for a long stretch while lookups keep coming, so
    // the output register fills and the block has to stall its input.
    task automatic test_output_backpressure();
        write_universe(32);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 400;
        for (int k = 0; k < 30; k++)
            send_word(pre_pkg::OP_LOOKUP, pick_id(), 1'b0);
    endtask

    // The register extremes: zero clamps to one object, the top value to all.
    task automatic test_register_extremes();
        write_universe(0);
        send_word(pre_pkg::OP_MEMBER, 0, 1'b0);
        send_word(pre_pkg::OP_MEMBER, 1, 1'b1);
        send_word(pre_pkg::OP_LOOKUP, 0, 1'b0);
        send_word(pre_pkg::OP_LOOKUP, 1, 1'b0);
        send_word(pre_pkg::OP_FINALIZE, 0, 1'b0);
        write_universe(2047);
        send_word(pre_pkg::OP_LOOKUP, 1023, 1'b0);
        send_word(pre_pkg::OP_FINALIZE, 0, 1'b1);
        send_word(pre_pkg::OP_LOOKUP, 1023, 1'b0);
    endtask

    // A group longer than the member store: one pass over every object, then
    // one extra member that must be dropped. Every set is covered whole.
    task automatic test_long_group();
        write_universe(MAX_OBJECTS);
        send_idle_pct  = 0;
        recv_stall_pct = 25;
        for (int k = 0; k <= MAX_GROUP; k++)
            send_word(pre_pkg::OP_MEMBER, k % MAX_OBJECTS, k == MAX_GROUP);
        send_word(pre_pkg::OP_LOOKUP, 512, 1'b0);
        // Splitting after the full pass still works.
        send_word(pre_pkg::OP_MEMBER, 100, 1'b0);
        send_word(pre_pkg::OP_MEMBER, 700, 1'b1);
        send_word(pre_pkg::OP_LOOKUP, 700, 1'b0);
    endtask

    // The receiver side: checks each answer taken.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("queued answers", 1, 0);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", int'(want.kind), int'(result_kind));
                if (set_id !== want.sid)
                    report_mismatch("set_id", int'(want.sid), int'(set_id));
                if (assigned !== want.asg)
                    report_mismatch("assigned", int'(want.asg), int'(assigned));
                if (member_count !== want.cnt)
                    report_mismatch("member_count", int'(want.cnt), int'(member_count));
                if (set_total !== want.tot)
                    report_mismatch("set_total", int'(want.tot), int'(set_total));
            end
        end
    end

    // The receiver's stall: a long hold counted down cycle by cycle, else
    // random stalls at the current rate.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
    end

    // Watchdog over the whole run, clearing pass included.
    always @(posedge clk)
    begin
        int cycles;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sets_used = 0;
        universe_reg = MAX_OBJECTS;
        foreach (owner[i])
        begin
            owner[i] = 0;
            set_size[i] = 0;
            hit_count[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_random_phase(80, 16, 0, 0);
        test_random_phase(80, 40, 52, 0);
        test_random_phase(80, 5, 0, 52);
        test_random_phase(80, 64, 25, 25);
        test_output_backpressure();
        test_random_phase(80, $urandom_range(200, 1), 25, 25);
        test_register_extremes();
        test_long_group();
        drain_answers();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
